// ===== rtl/core/rip_pkg.sv =====
// Shared constants and types for the routing-information record parser.
package rip_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CALL_BYTES   = 7;
    localparam int unsigned HEADER_BYTES = 10;
    localparam int unsigned ALIAS_BYTES  = 6;
    localparam int unsigned CALL_W       = CALL_BYTES * BYTE_W;
    localparam int unsigned TIME_W       = 16;
    localparam int unsigned ALIAS_W      = ALIAS_BYTES * BYTE_W;
    localparam int unsigned HDR_IDX_W    = 4;

    localparam logic [BYTE_W-1:0]  SPACE_CHAR   = 8'h20;
    localparam logic [ALIAS_W-1:0] ALIAS_SPACES = {ALIAS_BYTES{SPACE_CHAR}};

    // Byte values with a meaning of their own.
    localparam logic [BYTE_W-1:0] RECORD_END   = 8'h00;
    localparam logic [BYTE_W-1:0] ALIAS_OPCODE = 8'h00;

    // Result status codes.
    localparam logic STATUS_COMPLETE  = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef struct packed {
        logic [CALL_W-1:0]  node_call;
        logic [BYTE_W-1:0]  hop_count;
        logic [TIME_W-1:0]  trip_time;
        logic [ALIAS_W-1:0] node_alias;
        logic               status;
        logic               frame_end;
    } t_result;

endpackage

// ===== rtl/core/rip_in_if.sv =====
// Input byte channel of the routing-information record parser.
interface rip_in_if import rip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/rip_res_if.sv =====
// Result channel of the routing-information record parser.
interface rip_res_if import rip_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CALL_W-1:0]  node_call;
    logic [BYTE_W-1:0]  hop_count;
    logic [TIME_W-1:0]  trip_time;
    logic [ALIAS_W-1:0] node_alias;
    logic               status;
    logic               frame_end;

    modport source (output valid, output node_call, output hop_count, output trip_time,
                    output node_alias, output status, output frame_end, input ready);
    modport sink   (input valid, input node_call, input hop_count, input trip_time,
                    input node_alias, input status, input frame_end, output ready);
endinterface

// ===== rtl/core/rip_record.sv =====
// Record state registers and the per-byte parsing logic.
module rip_record import rip_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    output logic              o_emit,
    output t_result           o_result
);

    logic [HDR_IDX_W-1:0] r_header_index, n_header_index;
    logic                 r_in_options, n_in_options;
    logic [BYTE_W-1:0]    r_option_length, n_option_length;
    logic [BYTE_W-1:0]    r_option_position, n_option_position;
    logic                 r_alias_option, n_alias_option;
    logic [CALL_W-1:0]    r_call_shift, n_call_shift;
    logic [BYTE_W-1:0]    r_hops_hold, n_hops_hold;
    logic [TIME_W-1:0]    r_time_hold, n_time_hold;
    logic [ALIAS_W-1:0]   r_alias_hold, n_alias_hold;
    logic                 done;

    always_comb begin
        n_header_index    = r_header_index;
        n_in_options      = r_in_options;
        n_option_length   = r_option_length;
        n_option_position = r_option_position;
        n_alias_option    = r_alias_option;
        n_call_shift      = r_call_shift;
        n_hops_hold       = r_hops_hold;
        n_time_hold       = r_time_hold;
        n_alias_hold      = r_alias_hold;
        done              = 1'b0;

        if (!r_in_options) begin
            if (r_header_index < HDR_IDX_W'(CALL_BYTES)) begin
                n_call_shift = {r_call_shift[CALL_W-BYTE_W-1:0], i_data_byte};
            end else if (r_header_index == HDR_IDX_W'(CALL_BYTES)) begin
                n_hops_hold = i_data_byte;
            end else begin
                n_time_hold = {r_time_hold[TIME_W-BYTE_W-1:0], i_data_byte};
            end
            n_header_index = r_header_index + 1'b1;
            if (n_header_index >= HDR_IDX_W'(HEADER_BYTES)) begin
                n_in_options = 1'b1;
            end
        end else if (r_option_position == '0) begin
            if (i_data_byte == RECORD_END) begin
                done = 1'b1;
            end else begin
                n_option_length = i_data_byte;
                n_alias_option  = 1'b0;
                // A length of one covers only the length byte itself.
                n_option_position = (i_data_byte <= 8'd1) ? '0 : 8'd1;
            end
        end else begin
            if (r_option_position == 8'd1) begin
                n_alias_option = (i_data_byte == ALIAS_OPCODE);
            end else if (r_alias_option) begin
                // Alias bytes land by position; anything past the sixth is dropped.
                for (int k = 0; k < ALIAS_BYTES; k++) begin
                    if (r_option_position == BYTE_W'(k + 2)) begin
                        n_alias_hold[BYTE_W*(ALIAS_BYTES-1-k) +: BYTE_W] = i_data_byte;
                    end
                end
            end
            n_option_position = r_option_position + 1'b1;
            if (n_option_position >= r_option_length) begin
                n_option_position = '0;
            end
        end
    end

    assign o_emit              = done | i_last_byte;
    assign o_result.node_call  = n_call_shift;
    assign o_result.hop_count  = n_hops_hold;
    assign o_result.trip_time  = n_time_hold;
    assign o_result.node_alias = n_alias_hold;
    assign o_result.status     = done ? STATUS_COMPLETE : STATUS_TRUNCATED;
    assign o_result.frame_end  = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && o_emit)) begin
            r_header_index    <= '0;
            r_in_options      <= 1'b0;
            r_option_length   <= '0;
            r_option_position <= '0;
            r_alias_option    <= 1'b0;
            r_call_shift      <= '0;
            r_hops_hold       <= '0;
            r_time_hold       <= '0;
            r_alias_hold      <= ALIAS_SPACES;
        end else if (i_accept) begin
            r_header_index    <= n_header_index;
            r_in_options      <= n_in_options;
            r_option_length   <= n_option_length;
            r_option_position <= n_option_position;
            r_alias_option    <= n_alias_option;
            r_call_shift      <= n_call_shift;
            r_hops_hold       <= n_hops_hold;
            r_time_hold       <= n_time_hold;
            r_alias_hold      <= n_alias_hold;
        end
    end

    a_options_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_options |-> (r_header_index == HDR_IDX_W'(HEADER_BYTES)))
        else $error("option parsing entered before the header was complete");

    a_position_in_option: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_option_position != '0) |-> (r_option_position < r_option_length))
        else $error("option position ran past the option length");

    a_truncated_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !i_last_byte) |-> (o_result.status == STATUS_COMPLETE))
        else $error("truncated status given inside a frame");

endmodule

// ===== rtl/core/rip_out_stage.sv =====
// Two-entry result register that keeps the input side moving while a result waits.
module rip_out_stage import rip_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_take
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;
    logic    pop;

    assign pop     = r_out_valid & i_take;
    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_data <= i_data;
            end else begin
                r_skid_data <= i_data;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the output register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("result pushed into a full output stage");

    a_skid_moves_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_take) |=> (r_out_valid && !r_skid_valid
                                      && (r_out_data == $past(r_skid_data))))
        else $error("skid entry lost when the output was taken");

endmodule

// ===== rtl/core/routing_info_record_parser_core.sv =====
// Top level of the routing-information record parser.
// A record result is registered in the result stage when the byte that closes it is accepted.
// One frame byte per cycle while i_in is ready; record registers update on each accepted byte.
// A two-entry result stage keeps i_in ready while one result waits; ready drops when both fill.
// Reset (synchronous, active low) returns the record state to its empty values, alias to spaces,
// and empties the result stage.
module routing_info_record_parser_core import rip_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rip_in_if.sink    i_in,
    rip_res_if.source o_res
);

    logic    accept;
    logic    emit;
    logic    stage_ready;
    t_result rec_result;
    t_result res_data;

    assign accept   = i_in.valid & stage_ready;
    assign i_in.ready = stage_ready;

    rip_record u_record (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_emit      (emit),
        .o_result    (rec_result)
    );

    rip_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept & emit),
        .i_data  (rec_result),
        .o_ready (stage_ready),
        .o_valid (o_res.valid),
        .o_data  (res_data),
        .i_take  (o_res.ready)
    );

    assign o_res.node_call  = res_data.node_call;
    assign o_res.hop_count  = res_data.hop_count;
    assign o_res.trip_time  = res_data.trip_time;
    assign o_res.node_alias = res_data.node_alias;
    assign o_res.status     = res_data.status;
    assign o_res.frame_end  = res_data.frame_end;

endmodule
